// ----- hw/rtl/psrs_pkg.sv -----
// ----------------------------------------------------------------------------
// psrs_pkg
// Shared constants for the power sum residue sieve search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package psrs_pkg;

    localparam int NUM_MODULI_DEF = 4;
    localparam int MOD_BITS_DEF   = 16;
    localparam int MAX_BASE_DEF   = 255;
    localparam int MAX_POWER_DEF  = 31;

    localparam int BASE_W  = 8;
    localparam int POWER_W = 5;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int USE_W   = 3;
    localparam int ACT_W   = 2;
    localparam int REG_MOD_W = 16;

    // lowest exponent stored in the power tables
    localparam logic [POWER_W-1:0] FIRST_POWER = 5'd3;

    localparam logic [ACT_W-1:0] ACT_PREPARE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BEGIN   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_NEXT    = 2'd2;

    localparam logic [IDX_W-1:0] REG_MAX_BASE      = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_POWER     = 3'd1;
    localparam logic [IDX_W-1:0] REG_MODULUS_0     = 3'd2;
    localparam logic [IDX_W-1:0] REG_MODULUS_1     = 3'd3;
    localparam logic [IDX_W-1:0] REG_MODULUS_2     = 3'd4;
    localparam logic [IDX_W-1:0] REG_MODULUS_3     = 3'd5;
    localparam logic [IDX_W-1:0] REG_MODULI_IN_USE = 3'd6;

    localparam logic [BASE_W-1:0]  MAX_BASE_RST  = 8'd16;
    localparam logic [POWER_W-1:0] MAX_POWER_RST = 5'd8;
    localparam logic [USE_W-1:0]   IN_USE_RST    = 3'd1;

    localparam logic [REG_MOD_W-1:0] MOD_RST [4] = '{16'd65521, 16'd65519, 16'd65497, 16'd65479};

endpackage

`default_nettype wire

// ----- hw/rtl/power_sum_residue_sieve_search_unit.sv -----
// ----------------------------------------------------------------------------
// power_sum_residue_sieve_search_unit
// Residue sieve search for candidate points of a^x + b^y = c^z, with the
// power table and the residue bitmap held in synchronous memories.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  command   start / busy           action, base_a
//  result    done (one cycle)       point_a, point_x, point_b, point_y,
//                                   found, exhausted
//  config    cfg_we                 cfg_index, cfg_data
//
//  Begin, unused actions and next after exhaustion answer in the cycle after start.
//  Prepare: clears all 2^(IW+MOD_BITS) bitmap entries, then runs the mulmod unit
//  once per power (NUM_MODULI * max_base * max_power), storing from FIRST_POWER.
//  Next: per point tried, an advance step, then a read, sum and check per used
//  modulus until one misses; a step and a binary gcd for each new b; one beat at
//  a time, busy meanwhile.
//  The receiver cannot stall; done marks the result beat for one cycle.
//  Reset is asynchronous; memory contents are not cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module power_sum_residue_sieve_search_unit #(
    parameter int NUM_MODULI = psrs_pkg::NUM_MODULI_DEF,
    parameter int MOD_BITS   = psrs_pkg::MOD_BITS_DEF,
    parameter int MAX_BASE   = psrs_pkg::MAX_BASE_DEF,
    parameter int MAX_POWER  = psrs_pkg::MAX_POWER_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [psrs_pkg::ACT_W-1:0]    action,
    input  wire logic [psrs_pkg::BASE_W-1:0]   base_a,
    output logic                               done,
    output logic [psrs_pkg::BASE_W-1:0]        point_a,
    output logic [psrs_pkg::POWER_W-1:0]       point_x,
    output logic [psrs_pkg::BASE_W-1:0]        point_b,
    output logic [psrs_pkg::POWER_W-1:0]       point_y,
    output logic                               found,
    output logic                               exhausted,
    input  wire logic                          cfg_we,
    input  wire logic [psrs_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [psrs_pkg::CFG_W-1:0]    cfg_data
);

    localparam int AW  = psrs_pkg::BASE_W;
    localparam int XW  = psrs_pkg::POWER_W;
    localparam int IW  = (NUM_MODULI > 1) ? $clog2(NUM_MODULI) : 1;
    localparam int BW  = (MAX_BASE > 1) ? $clog2(MAX_BASE + 1) : 1;
    localparam int PW  = $clog2(MAX_POWER + 1);
    localparam int PTW = IW + BW + PW;
    localparam int BMW = IW + MOD_BITS;
    localparam int MW  = (MOD_BITS > psrs_pkg::REG_MOD_W) ? MOD_BITS : psrs_pkg::REG_MOD_W;
    localparam int UW  = psrs_pkg::USE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_PCSTART, S_PMSTART, S_PMWAIT,
        S_ADV, S_BNEXT, S_GCD, S_TSTART, S_TRD, S_TSUM, S_TCHK
    } state_t;

    // configuration
    logic [AW-1:0] max_base_reg;
    logic [XW-1:0] max_power_reg;
    logic [UW-1:0] in_use_reg;
    logic [psrs_pkg::REG_MOD_W-1:0] mod_reg [NUM_MODULI];

    logic [AW-1:0] mb;
    logic [XW-1:0] mp;
    logic [UW-1:0] n_use;
    logic [MOD_BITS-1:0] mod_eff [NUM_MODULI];

    // control and cursor
    state_t state_reg;
    logic [BMW-1:0] clr_cnt_reg;
    logic [IW-1:0] pi_reg;
    logic [IW-1:0] ti_reg;
    logic [AW-1:0] pc_reg;
    logic [XW-1:0] pz_reg;
    logic [MOD_BITS-1:0] r_reg;
    logic [AW-1:0] cur_a_reg;
    logic [XW-1:0] cur_x_reg;
    logic [AW-1:0] cur_b_reg;
    logic [XW-1:0] cur_y_reg;
    logic over_reg;
    logic [AW-1:0] gu_reg;
    logic [AW-1:0] gv_reg;

    logic done_reg;
    logic [AW-1:0] point_a_reg;
    logic [XW-1:0] point_x_reg;
    logic [AW-1:0] point_b_reg;
    logic [XW-1:0] point_y_reg;
    logic found_reg;
    logic exhausted_reg;

    // memories
    logic [MOD_BITS-1:0] pt_mem [2**PTW];
    logic bm_mem [2**BMW];
    logic [MOD_BITS-1:0] pt_rd0_reg;
    logic [MOD_BITS-1:0] pt_rd1_reg;
    logic bm_rd_reg;

    logic pt_we;
    logic [PTW-1:0] pt_waddr;
    logic [PTW-1:0] pt_raddr0;
    logic [PTW-1:0] pt_raddr1;
    logic bm_we;
    logic [BMW-1:0] bm_waddr;
    logic bm_wdata;
    logic [BMW-1:0] bm_raddr;

    logic mm_start;
    logic mm_done;
    logic [MOD_BITS-1:0] mm_res;

    logic [MOD_BITS:0] sum;
    logic [MOD_BITS:0] sum_mod;
    logic [MOD_BITS-1:0] m_test;
    logic [XW:0] y_inc;
    logic [XW:0] x_inc;
    logic [AW:0] b_inc;
    logic begin_over;

    function automatic logic [psrs_pkg::IDX_W-1:0] IDX_CAST(input int v);
        return psrs_pkg::IDX_W'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_base_reg  <= psrs_pkg::MAX_BASE_RST;
            max_power_reg <= psrs_pkg::MAX_POWER_RST;
            in_use_reg    <= psrs_pkg::IN_USE_RST;
            for (int i = 0; i < NUM_MODULI; i++)
            begin
                mod_reg[i] <= psrs_pkg::MOD_RST[i];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psrs_pkg::REG_MAX_BASE:      max_base_reg  <= cfg_data[AW-1:0];
                psrs_pkg::REG_MAX_POWER:     max_power_reg <= cfg_data[XW-1:0];
                psrs_pkg::REG_MODULI_IN_USE: in_use_reg    <= cfg_data[UW-1:0];
                psrs_pkg::REG_MODULUS_0, psrs_pkg::REG_MODULUS_1,
                psrs_pkg::REG_MODULUS_2, psrs_pkg::REG_MODULUS_3:
                begin
                    for (int i = 0; i < NUM_MODULI; i++)
                    begin
                        if (cfg_index == psrs_pkg::REG_MODULUS_0 + IDX_CAST(i))
                        begin
                            mod_reg[i] <= cfg_data[psrs_pkg::REG_MOD_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // clamped register views
    always_comb
    begin
        if (max_base_reg == '0)
            mb = AW'(1);
        else if (max_base_reg > AW'(MAX_BASE))
            mb = AW'(MAX_BASE);
        else
            mb = max_base_reg;

        if (max_power_reg < psrs_pkg::FIRST_POWER)
            mp = psrs_pkg::FIRST_POWER;
        else if (max_power_reg > XW'(MAX_POWER))
            mp = XW'(MAX_POWER);
        else
            mp = max_power_reg;

        n_use = (in_use_reg > UW'(NUM_MODULI)) ? UW'(NUM_MODULI) : in_use_reg;
    end

    for (genvar g = 0; g < NUM_MODULI; g++)
    begin : g_mod
        logic [MW-1:0] ext;
        assign ext = MW'(mod_reg[g]);
        // a modulus that narrows to zero behaves as one
        assign mod_eff[g] = (ext[MOD_BITS-1:0] == '0) ? MOD_BITS'(1) : ext[MOD_BITS-1:0];
    end

    psrs_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .r     (r_reg),
        .c     (pc_reg),
        .m     (mod_eff[pi_reg]),
        .done  (mm_done),
        .res   (mm_res)
    );

    // memory ports
    always_comb
    begin
        mm_start  = (state_reg == S_PMSTART);
        pt_we     = (state_reg == S_PMWAIT) && mm_done && (pz_reg >= psrs_pkg::FIRST_POWER);
        pt_waddr  = {pi_reg, BW'(pc_reg), PW'(pz_reg)};
        bm_we     = (state_reg == S_CLR) || pt_we;
        bm_waddr  = (state_reg == S_CLR) ? clr_cnt_reg : {pi_reg, mm_res};
        bm_wdata  = (state_reg != S_CLR);
        pt_raddr0 = {ti_reg, BW'(cur_a_reg), PW'(cur_x_reg)};
        pt_raddr1 = {ti_reg, BW'(cur_b_reg), PW'(cur_y_reg)};
        m_test    = mod_eff[ti_reg];
        sum       = {1'b0, pt_rd0_reg} + {1'b0, pt_rd1_reg};
        // both terms are below m, so one subtraction reduces the sum
        sum_mod   = (sum >= {1'b0, m_test}) ? (sum - {1'b0, m_test}) : sum;
        bm_raddr  = {ti_reg, sum_mod[MOD_BITS-1:0]};
        y_inc     = {1'b0, cur_y_reg} + (XW+1)'(1);
        x_inc     = {1'b0, cur_x_reg} + (XW+1)'(1);
        b_inc     = {1'b0, cur_b_reg} + (AW+1)'(1);
        begin_over = (base_a == '0) || (base_a > mb);
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= mm_res;
        end
        pt_rd0_reg <= pt_mem[pt_raddr0];
        pt_rd1_reg <= pt_mem[pt_raddr1];
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        bm_rd_reg <= bm_mem[bm_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clr_cnt_reg   <= '0;
            pi_reg        <= '0;
            ti_reg        <= '0;
            pc_reg        <= AW'(1);
            pz_reg        <= XW'(1);
            r_reg         <= '0;
            cur_a_reg     <= '0;
            cur_x_reg     <= psrs_pkg::FIRST_POWER;
            cur_b_reg     <= AW'(1);
            cur_y_reg     <= XW'(2);
            over_reg      <= 1'b1;
            gu_reg        <= '0;
            gv_reg        <= '0;
            done_reg      <= 1'b0;
            point_a_reg   <= '0;
            point_x_reg   <= '0;
            point_b_reg   <= '0;
            point_y_reg   <= '0;
            found_reg     <= 1'b0;
            exhausted_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        point_a_reg <= '0;
                        point_x_reg <= '0;
                        point_b_reg <= '0;
                        point_y_reg <= '0;
                        found_reg   <= 1'b0;
                        case (action)
                            psrs_pkg::ACT_PREPARE:
                            begin
                                clr_cnt_reg <= '0;
                                state_reg   <= S_CLR;
                            end
                            psrs_pkg::ACT_BEGIN:
                            begin
                                cur_a_reg     <= base_a;
                                cur_x_reg     <= psrs_pkg::FIRST_POWER;
                                cur_b_reg     <= AW'(1);
                                cur_y_reg     <= XW'(2);
                                over_reg      <= begin_over;
                                exhausted_reg <= begin_over;
                                done_reg      <= 1'b1;
                            end
                            psrs_pkg::ACT_NEXT:
                            begin
                                if (over_reg)
                                begin
                                    exhausted_reg <= 1'b1;
                                    done_reg      <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_ADV;
                                end
                            end
                            default:
                            begin
                                exhausted_reg <= over_reg;
                                done_reg      <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + BMW'(1);
                    if (&clr_cnt_reg)
                    begin
                        pi_reg    <= '0;
                        pc_reg    <= AW'(1);
                        state_reg <= S_PCSTART;
                    end
                end
                S_PCSTART:
                begin
                    r_reg     <= (mod_eff[pi_reg] == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                    pz_reg    <= XW'(1);
                    state_reg <= S_PMSTART;
                end
                S_PMSTART:
                begin
                    state_reg <= S_PMWAIT;
                end
                S_PMWAIT:
                begin
                    if (mm_done)
                    begin
                        r_reg <= mm_res;
                        if (pz_reg == mp)
                        begin
                            if (pc_reg == mb)
                            begin
                                if (pi_reg == IW'(NUM_MODULI - 1))
                                begin
                                    exhausted_reg <= over_reg;
                                    done_reg      <= 1'b1;
                                    state_reg     <= S_IDLE;
                                end
                                else
                                begin
                                    pi_reg    <= pi_reg + IW'(1);
                                    pc_reg    <= AW'(1);
                                    state_reg <= S_PCSTART;
                                end
                            end
                            else
                            begin
                                pc_reg    <= pc_reg + AW'(1);
                                state_reg <= S_PCSTART;
                            end
                        end
                        else
                        begin
                            pz_reg    <= pz_reg + XW'(1);
                            state_reg <= S_PMSTART;
                        end
                    end
                end
                S_ADV:
                begin
                    if (y_inc > {1'b0, mp})
                    begin
                        cur_y_reg <= psrs_pkg::FIRST_POWER;
                        if (x_inc > {1'b0, mp})
                        begin
                            cur_x_reg <= psrs_pkg::FIRST_POWER;
                            state_reg <= S_BNEXT;
                        end
                        else
                        begin
                            cur_x_reg <= x_inc[XW-1:0];
                            state_reg <= S_TSTART;
                        end
                    end
                    else
                    begin
                        cur_y_reg <= y_inc[XW-1:0];
                        state_reg <= S_TSTART;
                    end
                end
                S_BNEXT:
                begin
                    if (b_inc > {1'b0, cur_a_reg})
                    begin
                        over_reg      <= 1'b1;
                        exhausted_reg <= 1'b1;
                        done_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        cur_b_reg <= b_inc[AW-1:0];
                        // both even: common factor, try the next b straight away
                        if (cur_a_reg[0] || b_inc[0])
                        begin
                            gu_reg    <= cur_a_reg;
                            gv_reg    <= b_inc[AW-1:0];
                            state_reg <= S_GCD;
                        end
                    end
                end
                S_GCD:
                begin
                    // binary gcd on odd parts; ends at the odd part of gcd(a, b)
                    if (gu_reg == gv_reg)
                    begin
                        state_reg <= (gu_reg == AW'(1)) ? S_TSTART : S_BNEXT;
                    end
                    else if (!gu_reg[0])
                    begin
                        gu_reg <= gu_reg >> 1;
                    end
                    else if (!gv_reg[0])
                    begin
                        gv_reg <= gv_reg >> 1;
                    end
                    else if (gu_reg > gv_reg)
                    begin
                        gu_reg <= gu_reg - gv_reg;
                    end
                    else
                    begin
                        gv_reg <= gv_reg - gu_reg;
                    end
                end
                S_TSTART:
                begin
                    if (n_use == '0)
                    begin
                        point_a_reg   <= cur_a_reg;
                        point_x_reg   <= cur_x_reg;
                        point_b_reg   <= cur_b_reg;
                        point_y_reg   <= cur_y_reg;
                        found_reg     <= 1'b1;
                        exhausted_reg <= 1'b0;
                        done_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        ti_reg    <= '0;
                        state_reg <= S_TRD;
                    end
                end
                S_TRD:
                begin
                    state_reg <= S_TSUM;
                end
                S_TSUM:
                begin
                    state_reg <= S_TCHK;
                end
                S_TCHK:
                begin
                    if (!bm_rd_reg)
                    begin
                        state_reg <= S_ADV;
                    end
                    else if (UW'(ti_reg) + UW'(1) == n_use)
                    begin
                        point_a_reg   <= cur_a_reg;
                        point_x_reg   <= cur_x_reg;
                        point_b_reg   <= cur_b_reg;
                        point_y_reg   <= cur_y_reg;
                        found_reg     <= 1'b1;
                        exhausted_reg <= 1'b0;
                        done_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        ti_reg    <= ti_reg + IW'(1);
                        state_reg <= S_TRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign point_a   = point_a_reg;
    assign point_x   = point_x_reg;
    assign point_b   = point_b_reg;
    assign point_y   = point_y_reg;
    assign found     = found_reg;
    assign exhausted = exhausted_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> !exhausted && point_b != '0 && point_b <= point_a)
        else $error("found point with bad base b or exhausted flag");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted beat neither worked on nor answered");

endmodule

`default_nettype wire

// ----- hw/rtl/psrs_mulmod.sv -----
// ----------------------------------------------------------------------------
// psrs_mulmod
// Iterative (r * c) mod m: one multiply, then one restoring step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psrs_mulmod #(
    parameter int MOD_BITS = psrs_pkg::MOD_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [MOD_BITS-1:0]         r,
    input  wire logic [psrs_pkg::BASE_W-1:0] c,
    input  wire logic [MOD_BITS-1:0]         m,
    output logic                             done,
    output logic [MOD_BITS-1:0]              res
);

    localparam int BW = psrs_pkg::BASE_W;
    localparam int RW = MOD_BITS + BW;
    localparam int KW = $clog2(BW);

    logic [RW-1:0] rem_reg;
    logic [MOD_BITS-1:0] m_reg;
    logic [KW-1:0] k_reg;
    logic run_reg;
    logic done_reg;
    logic [RW-1:0] shifted;

    // quotient is below 2^BW, so BW restoring steps leave the remainder
    assign shifted = {{BW{1'b0}}, m_reg} << k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                k_reg   <= KW'(BW - 1);
                m_reg   <= m;
                rem_reg <= RW'(r) * RW'(c);
            end
            else if (run_reg)
            begin
                if (rem_reg >= shifted)
                begin
                    rem_reg <= rem_reg - shifted;
                end
                if (k_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg - KW'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = rem_reg[MOD_BITS-1:0];

endmodule

`default_nettype wire
